// ===== hdl/dfcw_pkg.sv =====
// Shared types, constants, microprogram and helper functions for the depth-first walk.
package dfcw_pkg;

    localparam int VERTICES = 8;
    localparam int VW       = $clog2(VERTICES);
    localparam int CW       = $clog2(VERTICES + 1);
    localparam int DW       = $clog2(VERTICES + 1);

    localparam logic [VERTICES-1:0] ALL_VISITED = {VERTICES{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_ROOT,
        ST_WALK
    } t_step;

    typedef enum logic [1:0] {
        C_RUN,
        C_DONE,
        C_EMPTY
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  do_root;
        logic  do_walk;
        t_cond cond;
        t_step tgt;
        t_step nxt;
    } t_ctrl;

    typedef struct packed {
        logic run_req;
        logic all_visited;
        logic empty;
        logic stall;
    } t_status;

    // Control store: wait for a request, pick a root, walk until the stack drains.
    function automatic t_ctrl prog(input t_step step);
        t_ctrl c;
        c = '{accept: 1'b0, do_root: 1'b0, do_walk: 1'b0,
              cond: C_RUN, tgt: ST_WAIT, nxt: ST_WAIT};
        case (step)
            ST_WAIT: begin
                c.accept = 1'b1;
                c.cond   = C_RUN;
                c.tgt    = ST_ROOT;
                c.nxt    = ST_WAIT;
            end
            ST_ROOT: begin
                c.do_root = 1'b1;
                c.cond    = C_DONE;
                c.tgt     = ST_WAIT;
                c.nxt     = ST_WALK;
            end
            ST_WALK: begin
                c.do_walk = 1'b1;
                c.cond    = C_EMPTY;
                c.tgt     = ST_ROOT;
                c.nxt     = ST_WALK;
            end
            default: begin
                c.cond = C_RUN;
                c.tgt  = ST_WAIT;
                c.nxt  = ST_WAIT;
            end
        endcase
        return c;
    endfunction

    function automatic logic [VW-1:0] lowest_set(input logic [VERTICES-1:0] bits);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = VERTICES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/dfcw_seq.sv =====
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module dfcw_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dfcw_pkg::t_status i_status,
    output dfcw_pkg::t_ctrl   o_ctrl
);

    dfcw_pkg::t_step r_step;
    dfcw_pkg::t_step n_step;
    logic            cond_true;

    assign o_ctrl = dfcw_pkg::prog(r_step);

    always_comb begin
        case (o_ctrl.cond)
            dfcw_pkg::C_RUN:   cond_true = i_status.run_req;
            dfcw_pkg::C_DONE:  cond_true = i_status.all_visited;
            dfcw_pkg::C_EMPTY: cond_true = i_status.empty;
            default:           cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (i_status.stall) begin
            n_step = r_step;
        end else if (cond_true) begin
            n_step = o_ctrl.tgt;
        end else begin
            n_step = o_ctrl.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dfcw_pkg::ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== hdl/depth_first_component_walk.sv =====
// Depth-first component walk over an 8-vertex adjacency matrix, microcoded control.
// Load request: stores one adjacency row, no result.
// Run request: acceptance moves the sequencer to the root step, whose first visit is then
// registered in the output register; a run is a visit and a pop step per vertex, an empty
// check per component, a closing root step and the accepting step; an output stall holds a step.
// Reset (synchronous, active low) clears the adjacency rows, walk state and output valid.
module depth_first_component_walk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [2:0] i_row_index,
    input  logic [7:0] i_row_bits,
    input  logic [2:0] i_start_vertex,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_vertex,
    output logic [3:0] o_component,
    output logic       o_last,
    output logic       o_connected
);

    localparam int V  = dfcw_pkg::VERTICES;
    localparam int VW = dfcw_pkg::VW;
    localparam int CW = dfcw_pkg::CW;
    localparam int DW = dfcw_pkg::DW;

    dfcw_pkg::t_ctrl   ctrl;
    dfcw_pkg::t_status status;

    logic [V-1:0]  r_adj [V];
    logic [VW-1:0] r_stack [V];
    logic [V-1:0]  r_visited;
    logic [DW-1:0] r_depth;
    logic [CW-1:0] r_count;
    logic          r_first;
    logic [VW-1:0] r_start;

    logic          r_o_valid;
    logic [VW-1:0] r_o_vertex;
    logic [CW-1:0] r_o_comp;
    logic          r_o_last;
    logic          r_o_conn;

    logic          in_acc;
    logic          run_acc;
    logic          out_free;
    logic          all_vis;
    logic          empty;
    logic [VW-1:0] top;
    logic [V-1:0]  open;
    logic [VW-1:0] root;
    logic          root_visit;
    logic          walk_visit;
    logic          walk_pop;
    logic          need_out;
    logic          visit;
    logic [VW-1:0] visit_v;
    logic [CW-1:0] visit_comp;
    logic [V-1:0]  vis_after;

    dfcw_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    assign o_ready = ctrl.accept;
    assign in_acc  = i_valid && ctrl.accept;
    assign run_acc = in_acc && (i_op == dfcw_pkg::OP_RUN);

    assign out_free = !r_o_valid || i_ready;
    assign all_vis  = (r_visited == dfcw_pkg::ALL_VISITED);
    assign empty    = (r_depth == '0);
    assign top      = r_stack[r_depth[VW-1:0] - VW'(1)];
    assign open     = r_adj[top] & ~r_visited;
    assign root     = r_first ? r_start : dfcw_pkg::lowest_set(~r_visited);

    assign root_visit = ctrl.do_root && !all_vis;
    assign walk_visit = ctrl.do_walk && !empty && (open != '0);
    assign walk_pop   = ctrl.do_walk && !empty && (open == '0);
    assign need_out   = root_visit || walk_visit;
    assign visit      = need_out && out_free;

    assign visit_v    = root_visit ? root : dfcw_pkg::lowest_set(open);
    assign visit_comp = root_visit ? r_count + CW'(1) : r_count;
    assign vis_after  = r_visited | (V'(1) << visit_v);

    assign status.run_req     = run_acc;
    assign status.all_visited = all_vis;
    assign status.empty       = empty;
    assign status.stall       = need_out && !out_free;

    // adjacency rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < V; i++) begin
                r_adj[i] <= '0;
            end
        end else if (in_acc && (i_op == dfcw_pkg::OP_LOAD)) begin
            r_adj[i_row_index] <= i_row_bits;
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_depth   <= '0;
            r_count   <= '0;
            r_first   <= 1'b0;
        end else if (run_acc) begin
            r_visited <= '0;
            r_depth   <= '0;
            r_count   <= '0;
            r_first   <= 1'b1;
        end else if (visit) begin
            r_visited <= vis_after;
            r_count   <= visit_comp;
            r_first   <= 1'b0;
            if (r_depth < DW'(V)) begin
                r_depth <= r_depth + DW'(1);
            end
        end else if (walk_pop) begin
            r_depth <= r_depth - DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_acc) begin
            r_start <= i_start_vertex;
        end
        if (visit && (r_depth < DW'(V))) begin
            r_stack[r_depth[VW-1:0]] <= visit_v;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (visit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (visit) begin
            r_o_vertex <= visit_v;
            r_o_comp   <= visit_comp;
            r_o_last   <= (vis_after == dfcw_pkg::ALL_VISITED);
            r_o_conn   <= (vis_after == dfcw_pkg::ALL_VISITED) && (visit_comp == CW'(1));
        end
    end

    assign o_valid     = r_o_valid;
    assign o_vertex    = r_o_vertex;
    assign o_component = r_o_comp;
    assign o_last      = r_o_last;
    assign o_connected = r_o_conn;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(V))
        else $error("stack depth beyond vertex count");

    a_new_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        visit |-> !r_visited[visit_v])
        else $error("vertex visited twice");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> empty)
        else $error("request taken with stack not drained");

    a_conn_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_connected) |-> o_last)
        else $error("connected flag off the final visit");

endmodule
